// File: sv/bgc_pkg.sv
// Package for the button gesture classifier: widths, event and register codes,
// configuration bundle. No dependencies.
package bgc_pkg;

  localparam int unsigned NowW      = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned TimeBitsD = 32;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PUSH   = 3'd1,
    EV_POP    = 3'd2,
    EV_SINGLE = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_HOLD   = 3'd5,
    EV_LONG   = 3'd6
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE  = 4'd0,
    REG_DC_GAP    = 4'd1,
    REG_HOLD      = 4'd2,
    REG_LONG_HOLD = 4'd3
  } cfg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst = 16'd20;
  localparam logic [CfgW-1:0] DcGapRst    = 16'd250;
  localparam logic [CfgW-1:0] HoldRst     = 16'd1000;
  localparam logic [CfgW-1:0] LongHoldRst = 16'd3000;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] double_click_gap_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] long_hold_ms;
  } cfg_t;

endpackage

// File: sv/bgc_if.sv
// Valid/ready channel interfaces: sample input, event output, register writes.
// Depends on bgc_pkg.
interface bgc_in_if import bgc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            button_level;
  logic [NowW-1:0] now_ms;

  modport source (output valid, button_level, now_ms, input ready);
  modport sink   (input valid, button_level, now_ms, output ready);
endinterface

interface bgc_out_if import bgc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

interface bgc_cfg_if import bgc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/bgc_cfg_regs.sv
// Timing configuration registers, written over the register channel.
// Depends on bgc_pkg and bgc_cfg_if.
module bgc_cfg_regs import bgc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bgc_cfg_if.sink    cfg,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEBOUNCE:  cfg_d.debounce_ms         = cfg.data;
        REG_DC_GAP:    cfg_d.double_click_gap_ms = cfg.data;
        REG_HOLD:      cfg_d.hold_ms             = cfg.data;
        REG_LONG_HOLD: cfg_d.long_hold_ms        = cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= DebounceRst;
      cfg_q.double_click_gap_ms <= DcGapRst;
      cfg_q.hold_ms             <= HoldRst;
      cfg_q.long_hold_ms        <= LongHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/bgc_classify.sv
// Debounce and gesture state with the per-sample classification logic.
// Depends on bgc_pkg.
module bgc_classify import bgc_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 level_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  cfg_t                 cfg_i,
  output event_e               event_o
);

  function automatic logic timed_out(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] start,
                                     logic [CfgW-1:0] limit);
    logic [TIME_BITS-1:0] diff;
    diff = now - start;
    return diff >= TIME_BITS'(limit);
  endfunction

  logic                 last_q, last_d, stable_q, stable_d, pend_q, pend_d;
  logic [TIME_BITS-1:0] cst_q, cst_d, press_q, press_d, rel_q, rel_d;
  logic                 dcw_q, dcw_d, dcr_q, dcr_d, single_q, single_d;
  logic                 ign_q, ign_d, hold_q, hold_d, lhold_q, lhold_d;
  event_e               ev;
  logic                 deb_rel, deb_press, gap_out, hold_out, lhold_out;

  assign deb_rel   = timed_out(now_i, rel_q, cfg_i.debounce_ms);
  assign deb_press = timed_out(now_i, press_q, cfg_i.debounce_ms);
  assign gap_out   = timed_out(now_i, rel_q, cfg_i.double_click_gap_ms);
  assign hold_out  = timed_out(now_i, press_q, cfg_i.hold_ms);
  assign lhold_out = timed_out(now_i, press_q, cfg_i.long_hold_ms);

  always_comb begin
    last_d   = last_q;
    stable_d = stable_q;
    pend_d   = pend_q;
    cst_d    = cst_q;
    press_d  = press_q;
    rel_d    = rel_q;
    dcw_d    = dcw_q;
    dcr_d    = dcr_q;
    single_d = single_q;
    ign_d    = ign_q;
    hold_d   = hold_q;
    lhold_d  = lhold_q;
    ev       = EV_NONE;
    if (level_i != stable_q) begin
      if (!pend_q) begin
        cst_d  = now_i;
        pend_d = 1'b1;
      end else if (timed_out(now_i, cst_q, cfg_i.debounce_ms)) begin
        ev       = stable_q ? EV_PUSH : EV_POP;
        stable_d = level_i;
        pend_d   = 1'b0;
      end
    end else begin
      priority if (!level_i && last_q && deb_rel) begin
        press_d  = now_i;
        ign_d    = 1'b0;
        single_d = 1'b1;
        hold_d   = 1'b0;
        lhold_d  = 1'b0;
        dcr_d    = !gap_out && !dcr_q && dcw_q;
        dcw_d    = 1'b0;
      end else if (level_i && !last_q && deb_press) begin
        if (!ign_q) begin
          rel_d = now_i;
          if (!dcr_q) begin
            dcw_d = 1'b1;
          end else begin
            ev       = EV_DOUBLE;
            dcr_d    = 1'b0;
            dcw_d    = 1'b0;
            single_d = 1'b0;
          end
        end
      end else if (level_i && gap_out && dcw_q && !dcr_q && single_q) begin
        ev    = EV_SINGLE;
        dcw_d = 1'b0;
      end else if (!level_i && hold_out) begin
        if (!hold_q) begin
          ev     = EV_HOLD;
          ign_d  = 1'b1;
          dcr_d  = 1'b0;
          dcw_d  = 1'b0;
          hold_d = 1'b1;
        end else if (lhold_out && !lhold_q) begin
          ev      = EV_LONG;
          lhold_d = 1'b1;
        end
      end else begin
      end
      last_d = level_i;
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      pend_q   <= 1'b0;
      cst_q    <= '0;
      press_q  <= '0;
      rel_q    <= '0;
      dcw_q    <= 1'b0;
      dcr_q    <= 1'b0;
      single_q <= 1'b1;
      ign_q    <= 1'b0;
      hold_q   <= 1'b0;
      lhold_q  <= 1'b0;
    end else if (step_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      pend_q   <= pend_d;
      cst_q    <= cst_d;
      press_q  <= press_d;
      rel_q    <= rel_d;
      dcw_q    <= dcw_d;
      dcr_q    <= dcr_d;
      single_q <= single_d;
      ign_q    <= ign_d;
      hold_q   <= hold_d;
      lhold_q  <= lhold_d;
    end
  end

endmodule

// File: sv/button_gesture_classifier.sv
// Top level of the button gesture classifier: sample register, classifier,
// event register. Depends on bgc_pkg, bgc_if, bgc_cfg_regs, bgc_classify.
//
// Usage: each beat on in_i carries one sampled button level (1 released,
// 0 pressed) with its millisecond timestamp; each input beat gives exactly
// one beat on res_o with an event code (none, push, pop, single, double,
// hold, long hold), in order. Timing registers are written on cfg_i, which
// is always ready; write only while no sample is in flight.
// Timing: an accepted sample is registered in the sample register, classified
// combinationally from there, and its event is loaded into the output register
// once that register is free, so a stalled res_o holds the sample in between.
// Throughput: one sample per cycle while res_o takes each event, as the classify
// step between the sample and event registers is combinational.
// Stall: if res_o is not taken, the event holds, the sample register still
// fills, and in_i.ready falls once both are occupied.
// Reset: both stages empty, timings back to 20/250/1000/3000 ms, button
// taken as released and stable.
module button_gesture_classifier import bgc_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsD
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bgc_in_if.sink   in_i,
  bgc_cfg_if.sink  cfg_i,
  bgc_out_if.source res_o
);

  cfg_t            cfg;
  logic            s1_valid_q, s1_valid_d, s1_level_q;
  logic [NowW-1:0] s1_now_q;
  logic            res_valid_q, res_valid_d;
  event_e          res_event_q, ev;
  logic            res_free, s1_adv, in_beat;

  assign res_free  = !res_valid_q || res_o.ready;
  assign s1_adv    = s1_valid_q && res_free;
  assign in_i.ready = !s1_valid_q || res_free;
  assign in_beat   = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_beat || (s1_valid_q && !s1_adv);
  assign res_valid_d = s1_adv || (res_valid_q && !res_o.ready);

  bgc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  bgc_classify #(.TIME_BITS(TIME_BITS)) u_cls (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .level_i (s1_level_q),
    .now_i   (TIME_BITS'(s1_now_q)),
    .cfg_i   (cfg),
    .event_o (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_level_q <= in_i.button_level;
      s1_now_q   <= in_i.now_ms;
    end
    if (s1_adv) begin
      res_event_q <= ev;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.event_code = res_event_q;

  a_adv_loads_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> res_valid_q)
    else $error("classified sample not loaded into event register");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_now_q) && $stable(s1_level_q)))
    else $error("stalled sample register lost its contents");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with an empty sample register");

  a_no_bubble_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready && s1_valid_q) |-> !in_i.ready)
    else $error("input accepted with both stages full");

endmodule
